@@ hdl/fir_filter_stream_defines.svh @@
// Assertion macros shared by the FIR filter stream RTL.
// Depends on nothing; the asserting module must provide aclk and aresetn.
`ifndef FIR_FILTER_STREAM_DEFINES_SVH
`define FIR_FILTER_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fir_pkg.sv @@
// Package for the FIR filter stream: sizes, data types and shared codes.
// Depends on nothing.
package fir_pkg;

    // Filter size and coefficient register count.
    localparam int TAPS      = 8;
    localparam int NUM_COEF  = 8;
    localparam int CFG_IDX_W = $clog2(NUM_COEF);

    // Data widths.
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int FRAC_W    = 15;

    // Adder tree shape: at least one level, leaves padded to a power of two.
    localparam int LEVELS    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int NPAD      = 1 << LEVELS;
    localparam int ACC_W     = PROD_W + LEVELS;
    localparam int Y_W       = ACC_W - FRAC_W;

    // Pipeline registers from accept to the rounded result: product, tree, round.
    localparam int DEPTH     = LEVELS + 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [Y_W-1:0]      y_t;

    // Command codes carried in the low tuser bit.
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Rounding and saturation constants.
    localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_W - 1);
    localparam y_t   Y_MAX      = y_t'(32767);
    localparam y_t   Y_MIN      = -y_t'(32768);

    // Control shared by every cell of the delay line.
    typedef struct packed {
        logic en;    // pipeline advances
        logic load;  // a beat is accepted: shift the delay line
        logic clr;   // the accepted beat starts a block
    } cell_ctrl_t;

    // One result beat.
    typedef struct packed {
        logic    clipped;
        sample_t filtered;
    } result_t;

endpackage

@@ hdl/fir_cell.sv @@
// One tap of the FIR delay line: a history register and a registered product.
// Depends on fir_pkg.
module fir_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                first,    // tap 0 sees the new sample directly
    input  fir_pkg::cell_ctrl_t ctrl,
    input  fir_pkg::sample_t    tap_in,   // tap value of the neighbor closer to the input
    input  fir_pkg::coef_t      coef,
    output fir_pkg::sample_t    tap_out,  // tap value of this cell for the current beat
    output fir_pkg::prod_t      prod_reg
);

    fir_pkg::sample_t hist_reg;

    // A block start makes the stored history read as zero.
    always_comb begin
        if (first) begin
            tap_out = tap_in;
        end else if (ctrl.clr) begin
            tap_out = '0;
        end else begin
            tap_out = hist_reg;
        end
    end

    // The delay line moves one place on every accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (ctrl.load) begin
            hist_reg <= tap_in;
        end
    end

    // Product stage.
    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            prod_reg <= coef * tap_out;
        end
    end

endmodule

@@ hdl/fir_tree.sv @@
// Registered binary adder tree that sums the tap products.
// Depends on fir_pkg.
module fir_tree (
    input  logic           aclk,
    input  logic           en,
    input  fir_pkg::prod_t prod [fir_pkg::TAPS],
    output fir_pkg::acc_t  sum
);

    fir_pkg::acc_t leaf    [fir_pkg::NPAD];
    fir_pkg::acc_t sum_reg [fir_pkg::LEVELS][fir_pkg::NPAD/2];

    // Sign-extend the products; pad leaves beyond the tap count with zero.
    for (genvar j = 0; j < fir_pkg::NPAD; j++) begin : g_leaf
        if (j < fir_pkg::TAPS) begin : g_used
            assign leaf[j] = fir_pkg::acc_t'(prod[j]);
        end else begin : g_pad
            assign leaf[j] = '0;
        end
    end

    // One register level per halving of the operand count.
    for (genvar l = 0; l < fir_pkg::LEVELS; l++) begin : g_level
        for (genvar j = 0; j < (fir_pkg::NPAD >> (l + 1)); j++) begin : g_node
            if (l == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (en) begin
                        sum_reg[l][j] <= leaf[2*j] + leaf[2*j+1];
                    end
                end
            end else begin : g_upper
                always_ff @(posedge aclk) begin
                    if (en) begin
                        sum_reg[l][j] <= sum_reg[l-1][2*j] + sum_reg[l-1][2*j+1];
                    end
                end
            end
        end
    end

    assign sum = sum_reg[fir_pkg::LEVELS-1][0];

endmodule

@@ hdl/fir_sat.sv @@
// Rounds the Q20.15 sum half up to an integer and saturates it to 16 bits.
// Depends on fir_pkg.
module fir_sat (
    input  logic              aclk,
    input  logic              en,
    input  fir_pkg::acc_t     acc,
    output fir_pkg::result_t  res_reg
);

    fir_pkg::acc_t    rnd;
    fir_pkg::y_t      y;
    fir_pkg::result_t res_next;

    // Add one half, then drop the fraction bits (floor).
    assign rnd = acc + fir_pkg::ROUND_HALF;
    assign y   = rnd[fir_pkg::ACC_W-1:fir_pkg::FRAC_W];

    // Clamp to the 16-bit range and flag the clamp.
    always_comb begin
        if (y > fir_pkg::Y_MAX) begin
            res_next.filtered = fir_pkg::sample_t'(fir_pkg::Y_MAX);
            res_next.clipped  = 1'b1;
        end else if (y < fir_pkg::Y_MIN) begin
            res_next.filtered = fir_pkg::sample_t'(fir_pkg::Y_MIN);
            res_next.clipped  = 1'b1;
        end else begin
            res_next.filtered = y[fir_pkg::SAMPLE_W-1:0];
            res_next.clipped  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

endmodule

@@ hdl/fir_filter_stream.sv @@
// Eight-tap direct-form FIR filter over a sample stream with block clearing and
// flush beats. The block takes one beat per clock while s_tready is high and
// returns one result beat for every input beat, in order; each result passes
// the product register, which loads at the accepting edge, then three adder-tree
// levels, the rounding register and the output register. A two-entry output
// stage lets input beats keep flowing while a result waits; s_tready drops
// only once both entries are full. Coefficients are signed Q1.15; the user must
// write them through the cfg port only while no beat is in flight, as the block
// itself does not enforce this.
// Depends on fir_pkg, fir_cell, fir_tree, fir_sat and the defines header.
`include "fir_filter_stream_defines.svh"

module fir_filter_stream (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] sample
    input  logic [1:0]                        s_tuser,   // [0] cmd, [1] block_start
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] filtered
    output logic [0:0]                        m_tuser,   // [0] clipped
    // Coefficient write port.
    input  logic                              cfg_wr_en,
    input  logic [fir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fir_pkg::COEF_W-1:0]        cfg_data
);

    fir_pkg::coef_t      coef_reg [fir_pkg::NUM_COEF];
    fir_pkg::cell_ctrl_t ctrl;
    fir_pkg::sample_t    x0;
    fir_pkg::sample_t    tap [fir_pkg::TAPS];
    fir_pkg::prod_t      prod [fir_pkg::TAPS];
    fir_pkg::acc_t       acc;
    fir_pkg::result_t    p_res;
    logic                p_valid;
    logic [fir_pkg::DEPTH-1:0] vld_reg;
    logic                accept;
    logic                out_ready;

    fir_pkg::result_t    out_reg;
    logic                out_valid_reg;
    fir_pkg::result_t    skid_reg;
    logic                skid_valid_reg;

    // Coefficient registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fir_pkg::NUM_COEF; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // The pipeline advances while the skid entry is free.
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign ctrl.en   = !skid_valid_reg;
    assign ctrl.load = accept;
    assign ctrl.clr  = s_tuser[1];

    // A flush beat feeds zero into the filter.
    assign x0 = (s_tuser[0] == fir_pkg::CMD_FLUSH) ? '0 : s_tdata;

    // Row of tap cells; each hands its tap value to the next.
    for (genvar k = 0; k < fir_pkg::TAPS; k++) begin : g_cell
        fir_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .first    (k == 0),
            .ctrl     (ctrl),
            .tap_in   ((k == 0) ? x0 : tap[(k == 0) ? 0 : k-1]),
            .coef     (coef_reg[k]),
            .tap_out  (tap[k]),
            .prod_reg (prod[k])
        );
    end

    fir_tree u_tree (
        .aclk (aclk),
        .en   (ctrl.en),
        .prod (prod),
        .sum  (acc)
    );

    fir_sat u_sat (
        .aclk    (aclk),
        .en      (ctrl.en),
        .acc     (acc),
        .res_reg (p_res)
    );

    // Valid bits that travel beside the data pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctrl.en) begin
            vld_reg <= {vld_reg[fir_pkg::DEPTH-2:0], accept};
        end
    end

    assign p_valid = vld_reg[fir_pkg::DEPTH-1];

    // Output register with a skid entry behind it.
    assign out_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (ctrl.en) begin
            if (out_ready) begin
                out_valid_reg <= p_valid;
            end else if (p_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_ready) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            if (out_ready) begin
                out_reg <= p_res;
            end else begin
                skid_reg <= p_res;
            end
        end else if (out_ready) begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.filtered;
    assign m_tuser[0] = out_reg.clipped;

    // A held skid beat always has a beat in front of it.
    `FIR_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry full while the output register is empty")

    // A finished result that meets a stalled output lands in the skid entry.
    `FIR_ASSERT_NEXT(a_result_kept, p_valid && ctrl.en && out_valid_reg && !m_tready,
        skid_valid_reg, "pipeline result dropped at a stalled output")

    // The skid entry is not emptied while the output stalls.
    `FIR_ASSERT_NEXT(a_skid_held, skid_valid_reg && !m_tready, skid_valid_reg,
        "skid entry lost during a stall")

    // A clipped result sits at one of the range limits.
    `FIR_ASSERT_NOW(a_clip_limit, m_tvalid && m_tuser[0],
        m_tdata == 16'h7fff || m_tdata == 16'h8000, "clipped result not at a limit")

endmodule

@@ dv/fir_filter_stream_tb.sv @@
// Self-checking testbench for fir_filter_stream: a scoreboard holds its own copy of the
// taps and the delay line and checks every result beat. It covers directed and random
// streams, coefficient sets and backpressure. Depends on fir_pkg and the fir_filter_stream RTL.
module fir_filter_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    typedef enum int {COEF_MAX, COEF_MIN, COEF_ALT, COEF_SMALL, COEF_RANDOM} coef_set_e;

    // Scoreboard: predicts each result from the accepted beats and checks the outputs.
    class fir_scoreboard;
        fir_pkg::coef_t   tap_coef[fir_pkg::NUM_COEF];
        fir_pkg::sample_t delay_line[fir_pkg::TAPS-1];
        fir_pkg::result_t expected_q[$];
        int               errors;

        function new();
            foreach (tap_coef[k]) tap_coef[k] = '0;
            foreach (delay_line[k]) delay_line[k] = '0;
            errors = 0;
        endfunction

        function void set_coef(int idx, fir_pkg::coef_t value);
            tap_coef[idx] = value;
        endfunction

        // An accepted input beat: form the filter sum, round, saturate, then shift.
        function void note_input(logic cmd, fir_pkg::sample_t smp, logic blk_start);
            fir_pkg::sample_t newest;
            longint           acc;
            longint           y;
            fir_pkg::result_t res;
            newest = (cmd == fir_pkg::CMD_FLUSH) ? fir_pkg::sample_t'(0) : smp;
            if (blk_start) begin
                foreach (delay_line[k]) delay_line[k] = '0;
            end
            acc = longint'(tap_coef[0]) * longint'(newest);
            for (int k = 1; k < fir_pkg::TAPS; k++) begin
                acc += longint'(tap_coef[k]) * longint'(delay_line[k-1]);
            end
            // Round half up, then clamp to the 16-bit range.
            y = (acc + 64'sd16384) >>> 15;
            res.clipped = 1'b0;
            if (y > 32767) begin
                y = 32767;
                res.clipped = 1'b1;
            end else if (y < -32768) begin
                y = -32768;
                res.clipped = 1'b1;
            end
            res.filtered = fir_pkg::sample_t'(y);
            for (int k = fir_pkg::TAPS - 2; k > 0; k--) begin
                delay_line[k] = delay_line[k-1];
            end
            delay_line[0] = newest;
            expected_q.push_back(res);
        endfunction

        // A result beat: compare it with the oldest prediction.
        function void check_result(logic [15:0] data, logic clip);
            fir_pkg::result_t exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat, filtered %0d clipped %0b",
                         $time, $signed(data), clip);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (exp_res.filtered !== fir_pkg::sample_t'(data)) begin
                $display("%0t: filtered mismatch, expected %0d, actual %0d",
                         $time, exp_res.filtered, $signed(data));
                errors++;
            end
            if (exp_res.clipped !== clip) begin
                $display("%0t: clipped mismatch, expected %0b, actual %0b",
                         $time, exp_res.clipped, clip);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [15:0]                   s_tdata;
    logic [1:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [15:0]                   m_tdata;
    logic [0:0]                    m_tuser;
    logic                          cfg_wr_en;
    logic [fir_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fir_pkg::COEF_W-1:0]    cfg_data;

    fir_scoreboard sb = new();
    bit            steady;
    int            hold_request;
    int            hold_left;
    int            cycle_count;

    fir_filter_stream dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("fir_filter_stream_tb failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 35);
        end
    end

    // Every result beat taken is checked.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    // Present one beat after an optional gap and wait until it is taken.
    task automatic send_item(logic cmd, fir_pkg::sample_t smp, logic blk_start);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= {blk_start, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, smp, blk_start);
    endtask

    // Stop offering beats and wait for every outstanding result.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic fir_pkg::coef_t pick_coef(coef_set_e set, int k);
        case (set)
            COEF_MAX:   return fir_pkg::coef_t'(32767);
            COEF_MIN:   return fir_pkg::coef_t'(-32768);
            COEF_ALT:   return (k % 2 == 1) ? fir_pkg::coef_t'(-32768) : fir_pkg::coef_t'(32767);
            COEF_SMALL: return fir_pkg::coef_t'(int'($urandom_range(8192)) - 4096);
            default:    return fir_pkg::coef_t'($urandom);
        endcase
    endfunction

    // Load all taps; only called while the filter is empty.
    task automatic write_coefs(coef_set_e set);
        fir_pkg::coef_t value;
        for (int k = 0; k < fir_pkg::NUM_COEF; k++) begin
            value = pick_coef(set, k);
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= k[fir_pkg::CFG_IDX_W-1:0];
            cfg_data  <= value;
            sb.set_coef(k, value);
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic fir_pkg::sample_t pick_sample();
        case ($urandom_range(5))
            0:       return fir_pkg::sample_t'(32767);
            1:       return fir_pkg::sample_t'(-32768);
            2:       return fir_pkg::sample_t'(int'($urandom_range(512)) - 256);
            default: return fir_pkg::sample_t'($urandom);
        endcase
    endfunction

    // Random traffic: mostly blocks of samples followed by a flush tail, some noise.
    task automatic run_random(int count, int hold_at);
        int sent;
        int run_len;
        int tail_len;
        sent = 0;
        while (sent < count) begin
            if (hold_at >= 0 && sent >= hold_at) begin
                hold_request = HOLD_CYCLES;
                hold_at = -1;
            end
            if ($urandom_range(99) < 80) begin
                run_len  = $urandom_range(24, 1);
                tail_len = $urandom_range(8);
                for (int i = 0; i < run_len; i++) begin
                    send_item(fir_pkg::CMD_PUSH, pick_sample(), i == 0);
                end
                for (int i = 0; i < tail_len; i++) begin
                    send_item(fir_pkg::CMD_FLUSH, fir_pkg::sample_t'($urandom), 1'b0);
                end
                sent += run_len + tail_len;
            end else begin
                run_len = $urandom_range(6, 1);
                for (int i = 0; i < run_len; i++) begin
                    send_item(logic'($urandom_range(1)), fir_pkg::sample_t'($urandom),
                              $urandom_range(3) == 0);
                end
                sent += run_len;
            end
        end
    endtask

    // Main sequence.
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_request = 0;
        hold_left    = 0;
        cycle_count  = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Taps at their reset value of zero.
        run_random(40, -1);

        // All taps at the positive extreme: build up to positive and negative clipping,
        // then a flush tail, a flush that starts a block, and a flush with a live sample.
        drain();
        write_coefs(COEF_MAX);
        send_item(fir_pkg::CMD_PUSH, 16'sd32767, 1'b1);
        repeat (3) send_item(fir_pkg::CMD_PUSH, 16'sd32767, 1'b0);
        send_item(fir_pkg::CMD_FLUSH, 16'sd0, 1'b0);
        send_item(fir_pkg::CMD_FLUSH, 16'sd1234, 1'b1);
        send_item(fir_pkg::CMD_PUSH, -16'sd32768, 1'b1);
        send_item(fir_pkg::CMD_PUSH, -16'sd32768, 1'b0);
        send_item(fir_pkg::CMD_PUSH, 16'sd0, 1'b0);
        repeat (7) send_item(fir_pkg::CMD_FLUSH, 16'sd0, 1'b0);
        send_item(fir_pkg::CMD_PUSH, 16'sd1, 1'b1);
        send_item(fir_pkg::CMD_PUSH, -16'sd1, 1'b0);
        send_item(fir_pkg::CMD_FLUSH, 16'sd32767, 1'b0);
        send_item(fir_pkg::CMD_PUSH, 16'sd100, 1'b1);
        run_random(200, -1);

        // All taps at the negative extreme: the most negative product clips high.
        drain();
        write_coefs(COEF_MIN);
        send_item(fir_pkg::CMD_PUSH, -16'sd32768, 1'b1);
        send_item(fir_pkg::CMD_PUSH, 16'sd32767, 1'b0);
        send_item(fir_pkg::CMD_FLUSH, -16'sd1, 1'b0);
        send_item(fir_pkg::CMD_FLUSH, 16'sd0, 1'b1);
        run_random(200, -1);

        // Alternating extremes with neither side idling.
        drain();
        write_coefs(COEF_ALT);
        steady = 1'b1;
        run_random(200, -1);
        steady = 1'b0;

        // Small taps, with a long receiver hold-off that fills the pipeline.
        drain();
        write_coefs(COEF_SMALL);
        run_random(200, 60);

        // Random taps, a new set per phase, alternating fully random and small sets.
        for (int p = 0; p < 5; p++) begin
            drain();
            write_coefs((p % 2 == 0) ? COEF_RANDOM : COEF_SMALL);
            run_random(220, -1);
        end

        drain();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("fir_filter_stream_tb passed");
        end else begin
            $display("fir_filter_stream_tb failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/fir_pkg.sv
hdl/fir_cell.sv
hdl/fir_tree.sv
hdl/fir_sat.sv
hdl/fir_filter_stream.sv
dv/fir_filter_stream_tb.sv
